/* rtl/core/safit_pkg.sv */
package safit_pkg;

	localparam int SIZE_W       = 16;
	localparam int REGION_W     = 16;
	localparam int GRANT_W      = 16;
	localparam int STATUS_W     = 2;
	localparam int IN_TDATA_W   = 32;
	localparam int OUT_TDATA_W  = 24;

	localparam int MAX_SLOTS_DEF   = 64;
	localparam int OFFSET_BITS_DEF = 16;

	localparam logic [REGION_W-1:0] REGION_RST = 16'd1024;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 2'd0,
		ST_NOROOM   = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic hit;
		logic miss;
		logic out_busy;
	} dp_sts_t;

endpackage

/* rtl/core/safit_ctrl.sv */
module safit_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  safit_pkg::dp_sts_t sts,
	output safit_pkg::ctl_cmd_t cmd
);
	import safit_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit || sts.miss) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/safit_dp.sv */
module safit_dp #(
	parameter int MAX_SLOTS   = safit_pkg::MAX_SLOTS_DEF,
	parameter int OFFSET_BITS = safit_pkg::OFFSET_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  safit_pkg::ctl_cmd_t             cmd,
	output safit_pkg::dp_sts_t              sts,
	input  safit_pkg::cmd_t                 req_cmd,
	input  logic [safit_pkg::SIZE_W-1:0]    req_size,
	input  logic [safit_pkg::SIZE_W-1:0]    req_ofs,
	input  logic                            cfg_wen,
	input  logic [safit_pkg::REGION_W-1:0]  cfg_wdata,
	input  logic                            out_ready,
	output logic                            out_valid,
	output safit_pkg::status_t              out_status,
	output logic [safit_pkg::GRANT_W-1:0]   out_grant
);
	import safit_pkg::*;

	localparam int IDX_W  = $clog2(MAX_SLOTS);
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int CMP_W  = (OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W;
	localparam int NEED_W = CMP_W + 1;

	logic [OFFSET_BITS-1:0] start_mem [MAX_SLOTS];
	logic [OFFSET_BITS-1:0] len_mem   [MAX_SLOTS];

	cmd_t                   cmd_q;
	logic [SIZE_W-1:0]      size_q;
	logic [SIZE_W-1:0]      ofs_q;
	logic [REGION_W-1:0]    region_q;
	logic [OFFSET_BITS-1:0] end_q;
	logic [CNT_W-1:0]       total_q;
	logic [MAX_SLOTS-1:0]   busy_q;
	logic [CNT_W-1:0]       issue_q;
	logic                   chk_vld_s1;
	logic [IDX_W-1:0]       chk_idx_s1;
	logic [OFFSET_BITS-1:0] rd_start_s1;
	logic [OFFSET_BITS-1:0] rd_len_s1;
	logic                   rd_busy_s1;
	logic                   hit_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [OFFSET_BITS-1:0] hit_start_q;
	logic                   out_valid_q;
	status_t                out_status_q;
	logic [GRANT_W-1:0]     out_grant_q;

	logic                   issue_en;
	logic                   match;
	logic [NEED_W-1:0]      need;
	logic                   fits;
	logic [IDX_W-1:0]       app_idx;
	logic                   app_we;
	status_t                res_status;
	logic [GRANT_W-1:0]     res_grant;

	assign issue_en = cmd.scan && (issue_q < total_q);
	assign app_idx  = total_q[IDX_W-1:0];
	assign need     = NEED_W'(end_q) + NEED_W'(size_q);
	assign fits     = (need <= NEED_W'(region_q)) && (total_q < CNT_W'(MAX_SLOTS));
	assign app_we   = cmd.commit && (cmd_q == CMD_ALLOC) && !hit_q && fits;

	always_comb begin
		match = 1'b0;
		if (chk_vld_s1) begin
			if (cmd_q == CMD_FREE) begin
				match = (CMP_W'(rd_start_s1) == CMP_W'(ofs_q));
			end else begin
				match = !rd_busy_s1 && (CMP_W'(rd_len_s1) >= CMP_W'(size_q));
			end
		end
	end

	always_comb begin
		res_status = ST_DONE;
		res_grant  = '0;
		if (cmd_q == CMD_FREE) begin
			if (!hit_q) begin
				res_status = ST_NOTFOUND;
			end
		end else if (hit_q) begin
			res_grant = GRANT_W'(hit_start_q);
		end else if (fits) begin
			res_grant = GRANT_W'(end_q);
		end else begin
			res_status = ST_NOROOM;
		end
	end

	assign sts.hit      = match;
	assign sts.miss     = !chk_vld_s1 && (issue_q == total_q);
	assign sts.out_busy = out_valid_q && !out_ready;

	// control state and slot bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q    <= REGION_RST;
			end_q       <= '0;
			total_q     <= '0;
			busy_q      <= '0;
			issue_q     <= '0;
			chk_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				region_q <= cfg_wdata;
			end
			chk_vld_s1 <= issue_en;
			if (cmd.load) begin
				issue_q <= '0;
				hit_q   <= 1'b0;
			end else if (issue_en) begin
				issue_q <= issue_q + 1'b1;
			end
			if (cmd.scan && match) begin
				hit_q <= 1'b1;
			end
			if (cmd.commit) begin
				if (hit_q) begin
					busy_q[hit_idx_q] <= (cmd_q == CMD_ALLOC);
				end else if (app_we) begin
					busy_q[app_idx] <= 1'b1;
					total_q         <= total_q + 1'b1;
					end_q           <= OFFSET_BITS'(need);
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request, scan and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= req_cmd;
			size_q <= req_size;
			ofs_q  <= req_ofs;
		end
		if (issue_en) begin
			chk_idx_s1 <= issue_q[IDX_W-1:0];
		end
		if (cmd.scan && match) begin
			hit_idx_q   <= chk_idx_s1;
			hit_start_q <= rd_start_s1;
		end
		if (cmd.commit) begin
			out_status_q <= res_status;
			out_grant_q  <= res_grant;
		end
	end

	// slot table
	always_ff @(posedge clk) begin
		if (app_we) begin
			start_mem[app_idx] <= end_q;
			len_mem[app_idx]   <= OFFSET_BITS'(size_q);
		end
		if (issue_en) begin
			rd_start_s1 <= start_mem[issue_q[IDX_W-1:0]];
			rd_len_s1   <= len_mem[issue_q[IDX_W-1:0]];
			rd_busy_s1  <= busy_q[issue_q[IDX_W-1:0]];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_grant  = out_grant_q;

endmodule

/* rtl/core/slot_allocator_first_fit.sv */
// channel   dir  signals                        contents
// s_        in   s_tvalid s_tready s_tdata s_tuser  request: cmd, alloc_size, free_offset
// m_        out  m_tvalid m_tready m_tdata       result: status, grant_offset
// cfg_      in   cfg_wen cfg_wdata                region_bytes
//
// the result follows the table scan, which reads one slot entry per cycle; a first-fit
// hit ends the scan early, and with no slots it misses at once; s_tready is high only
// while no request is in work, so a request is taken only once the last one's result is
// committed; a result waits in the output register while m_tready is low and holds the
// next result back; reset clears the busy bits, slot count and end offset and sets
// region_bytes to 1024; the slot memory is never cleared, only entries below the slot
// count are read
module slot_allocator_first_fit #(
	parameter int MAX_SLOTS   = safit_pkg::MAX_SLOTS_DEF,
	parameter int OFFSET_BITS = safit_pkg::OFFSET_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [safit_pkg::IN_TDATA_W-1:0]   s_tdata,   // alloc_size, free_offset
	input  logic [0:0]                         s_tuser,   // cmd
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [safit_pkg::OUT_TDATA_W-1:0]  m_tdata,   // status, grant_offset, zero pad
	input  logic                               cfg_wen,
	input  logic [safit_pkg::REGION_W-1:0]     cfg_wdata
);
	import safit_pkg::*;

	ctl_cmd_t           ctl_cmd;
	dp_sts_t            dp_sts;
	cmd_t               req_cmd;
	status_t            out_status;
	logic [GRANT_W-1:0] out_grant;

	assign req_cmd = cmd_t'(s_tuser[0]);

	safit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.sts       (dp_sts),
		.cmd       (ctl_cmd)
	);

	safit_dp #(
		.MAX_SLOTS   (MAX_SLOTS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ctl_cmd),
		.sts        (dp_sts),
		.req_cmd    (req_cmd),
		.req_size   (s_tdata[SIZE_W-1:0]),
		.req_ofs    (s_tdata[2*SIZE_W-1:SIZE_W]),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_status (out_status),
		.out_grant  (out_grant)
	);

	assign m_tdata = {{(OUT_TDATA_W - STATUS_W - GRANT_W){1'b0}}, out_grant, out_status};

	a_commit_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.commit |-> !(m_tvalid && !m_tready))
		else $error("result loaded over an unread result");

	a_one_request_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("new request taken while one is in work");

	a_commit_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.commit |=> m_tvalid)
		else $error("commit without a result");

endmodule

/* bench/slot_allocator_first_fit_tb.sv */
module slot_allocator_first_fit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import safit_pkg::*;

	localparam int SLOTS       = MAX_SLOTS_DEF;
	localparam int DRAIN_WAIT  = SLOTS + 8;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 350;
	localparam int HOLD_AT     = 700;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		status_t          status;
		logic [GRANT_W-1:0] grant;
	} grant_t;

	class alloc_scoreboard;
		bit                 busy[SLOTS];
		logic [SIZE_W-1:0]  start[SLOTS];
		logic [SIZE_W-1:0]  length[SLOTS];
		int                 total;
		logic [SIZE_W-1:0]  end_off;
		logic [REGION_W-1:0] region;
		grant_t             pending_grants[$];
		int                 errors;

		function new();
			total   = 0;
			end_off = '0;
			region  = REGION_RST;
			errors  = 0;
			foreach (busy[i]) busy[i] = 1'b0;
		endfunction

		function void set_region(logic [REGION_W-1:0] value);
			region = value;
		endfunction

		function int pending();
			return pending_grants.size();
		endfunction

		function logic [SIZE_W-1:0] pick_start();
			if (total == 0) return SIZE_W'($urandom);
			return start[$urandom_range(total - 1)];
		endfunction

		// alloc: first fit over the table, append at the end offset when nothing fits; free: first start match
		function void accept_request(cmd_t cmd, logic [SIZE_W-1:0] size,
			logic [SIZE_W-1:0] ofs);
			grant_t      g;
			bit          hit;
			logic [16:0] need;
			hit = 1'b0;
			g.grant = '0;
			if (cmd == CMD_ALLOC) begin
				for (int i = 0; i < total; i++) begin
					if (!hit && !busy[i] && length[i] >= size) begin
						busy[i]  = 1'b1;
						g.status = ST_DONE;
						g.grant  = start[i];
						hit      = 1'b1;
					end
				end
				if (!hit) begin
					need = {1'b0, end_off} + {1'b0, size};
					if (need > {1'b0, region} || total >= SLOTS) begin
						g.status = ST_NOROOM;
					end else begin
						busy[total]   = 1'b1;
						start[total]  = end_off;
						length[total] = size;
						total++;
						g.status = ST_DONE;
						g.grant  = end_off;
						end_off  = need[SIZE_W-1:0];
					end
				end
			end else begin
				g.status = ST_NOTFOUND;
				for (int i = 0; i < total; i++) begin
					if (!hit && start[i] == ofs) begin
						busy[i]  = 1'b0;
						g.status = ST_DONE;
						hit      = 1'b1;
					end
				end
			end
			pending_grants.push_back(g);
		endfunction

		function void check_grant(logic [OUT_TDATA_W-1:0] data);
			grant_t             g;
			logic [STATUS_W-1:0] got_status;
			logic [GRANT_W-1:0]  got_grant;
			got_status = data[STATUS_W-1:0];
			got_grant  = data[STATUS_W+GRANT_W-1:STATUS_W];
			if (pending_grants.size() == 0) begin
				$error("result with no request waiting: status %0d grant_offset %0d",
					got_status, got_grant);
				errors++;
				return;
			end
			g = pending_grants.pop_front();
			if (got_status !== g.status) begin
				$error("status: expected %0d, got %0d", g.status, got_status);
				errors++;
			end
			if (got_grant !== g.grant) begin
				$error("grant_offset: expected %0d, got %0d", g.grant, got_grant);
				errors++;
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [IN_TDATA_W-1:0]    s_tdata = '0;
	logic [0:0]               s_tuser = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]   m_tdata;
	logic                     cfg_wen = 1'b0;
	logic [REGION_W-1:0]      cfg_wdata = '0;

	alloc_scoreboard sb = new();
	int  sent_total = 0;
	int  stall_cycles = 0;
	bit  calm = 1'b0;

	slot_allocator_first_fit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result side: random stalls, one long hold once HOLD_AT requests have been sent
	always @(posedge clk) begin : receiver
		static int  hold_left = 0;
		static bit  held = 1'b0;
		if (!held && sent_total >= HOLD_AT) begin
			held      = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 31);
		end
	end

	always @(posedge clk) begin : monitor
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_grant(m_tdata);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("TEST FAILED");
					$finish;
				end
			end
		end
	end

	task automatic send_request(cmd_t cmd, logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] ofs);
		while (!calm && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {ofs, size};
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		sb.accept_request(cmd, size, ofs);
		sent_total++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_region(logic [REGION_W-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.set_region(value);
	endtask

	task automatic random_request();
		int                r;
		logic [SIZE_W-1:0] size;
		logic [SIZE_W-1:0] ofs;
		r = $urandom_range(99);
		if (r < 55) begin
			r = $urandom_range(99);
			if (r < 8) size = '0;
			else if (r < 70) size = SIZE_W'($urandom_range(64, 1));
			else if (r < 88) size = SIZE_W'($urandom_range(4095, 65));
			else size = SIZE_W'($urandom);
			send_request(CMD_ALLOC, size, SIZE_W'($urandom));
		end else begin
			r = $urandom_range(99);
			if (r < 75) ofs = sb.pick_start();
			else if (r < 88) ofs = SIZE_W'($urandom_range(1023));
			else ofs = SIZE_W'($urandom);
			send_request(CMD_FREE, SIZE_W'($urandom), ofs);
		end
	endtask

	initial begin
		logic [REGION_W-1:0] regions[5];
		int                  n;
		regions = '{16'd1024, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
		regions[3] = REGION_W'($urandom);
		n = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: small region so the region limit is reached quickly
		write_region(16'd40);
		send_request(CMD_FREE, 16'hFFFF, 16'd0);
		send_request(CMD_ALLOC, 16'hFFFF, 16'hFFFF);
		send_request(CMD_ALLOC, 16'd0, 16'd0);
		send_request(CMD_ALLOC, 16'd16, 16'd0);
		send_request(CMD_ALLOC, 16'd8, 16'hFFFF);
		send_request(CMD_FREE, 16'd0, 16'd0);
		send_request(CMD_ALLOC, 16'd4, 16'd0);
		send_request(CMD_FREE, 16'd0, 16'd0);
		send_request(CMD_ALLOC, 16'd0, 16'd0);
		send_request(CMD_FREE, 16'd0, 16'd16);
		send_request(CMD_FREE, 16'hFFFF, 16'd16);
		send_request(CMD_ALLOC, 16'd5, 16'd0);
		send_request(CMD_ALLOC, 16'd13, 16'd0);
		send_request(CMD_ALLOC, 16'd12, 16'd0);
		send_request(CMD_ALLOC, 16'd0, 16'd0);
		send_request(CMD_FREE, 16'hFFFF, 16'hFFFF);
		drain();
		// region shrunk below the end offset
		write_region(16'd20);
		send_request(CMD_FREE, 16'd0, 16'd28);
		send_request(CMD_ALLOC, 16'd12, 16'd0);
		send_request(CMD_ALLOC, 16'd0, 16'd0);
		send_request(CMD_FREE, 16'd0, 16'd24);
		send_request(CMD_ALLOC, 16'd1, 16'd0);
		drain();

		foreach (regions[p]) begin
			write_region(regions[p]);
			repeat (PHASE_ITEMS) begin
				calm = (n >= 150 && n < 400);
				if (n == 1000) drain();
				random_request();
				n++;
			end
			calm = 1'b0;
			drain();
		end

		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/safit_pkg.sv
rtl/core/safit_ctrl.sv
rtl/core/safit_dp.sv
rtl/core/slot_allocator_first_fit.sv
bench/slot_allocator_first_fit_tb.sv
